/* src/fin_pkg.sv */
// Package for the frame intensity normalizer: beat types, codes, widths and the
// lane control struct. It depends on nothing and is used by fin_lane, the top level and the checker.
package fin_pkg;

    localparam int MAX_PIXELS_DEF = 512;
    localparam int CHAN_W         = 8;
    localparam int INDEX_W        = 9;
    localparam int PEAK_W         = 18;
    localparam int SQ_W           = 2 * CHAN_W;
    localparam int C4_W           = 4 * CHAN_W;
    localparam int SUM_W          = C4_W + 3;
    localparam int DPROD_W        = PEAK_W + CHAN_W;
    localparam int PIXEL_W        = 3 * CHAN_W;
    localparam int STEP_W         = $clog2(CHAN_W);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_RANGE = 1'b1
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_QUAD,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic               first;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [INDEX_W-1:0] pixel_index;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic [INDEX_W-1:0] index_out;
        t_status            status;
    } t_out_beat;

    typedef struct packed {
        logic              square;
        logic              quad;
        logic              step;
        logic [STEP_W-1:0] k;
    } t_lane_ctl;

endpackage

/* src/fin_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module fin_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fin_lane.sv */
// One channel lane: squares the channel twice, then finds bit by bit the largest
// q with q*q*peak <= c**4, keeping q*peak and q*q*peak so no step multiplies. Uses fin_pkg.
module fin_lane (
    input  logic                       i_clk,
    input  fin_pkg::t_lane_ctl         i_ctl,
    input  logic [fin_pkg::CHAN_W-1:0] i_chan,
    input  logic [fin_pkg::PEAK_W-1:0] i_peak,
    output logic [fin_pkg::CHAN_W-1:0] o_q
);

    logic [fin_pkg::SQ_W-1:0]    r_c2;
    logic [fin_pkg::C4_W-1:0]    r_c4;
    logic [fin_pkg::C4_W-1:0]    r_s;
    logic [fin_pkg::DPROD_W-1:0] r_d;
    logic [fin_pkg::CHAN_W-1:0]  r_q;

    logic [fin_pkg::SUM_W-1:0]   trial;
    logic [fin_pkg::DPROD_W-1:0] peak_sh;
    logic                        fits;

    always_comb begin
        peak_sh = fin_pkg::DPROD_W'(i_peak) << i_ctl.k;
        trial   = fin_pkg::SUM_W'(r_s)
                + ((fin_pkg::SUM_W'(r_d) << 1) << i_ctl.k)
                + (fin_pkg::SUM_W'(peak_sh) << i_ctl.k);
        fits    = trial <= fin_pkg::SUM_W'(r_c4);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.square) begin
            r_c2 <= fin_pkg::SQ_W'(i_chan) * fin_pkg::SQ_W'(i_chan);
        end
        if (i_ctl.quad) begin
            r_c4 <= fin_pkg::C4_W'(r_c2) * fin_pkg::C4_W'(r_c2);
            r_s  <= '0;
            r_d  <= '0;
            r_q  <= '0;
        end else if (i_ctl.step && fits) begin
            r_s        <= trial[fin_pkg::C4_W-1:0];
            r_d        <= r_d + peak_sh;
            r_q[i_ctl.k] <= 1'b1;
        end
    end

    assign o_q = r_q;

endmodule

/* src/frame_intensity_normalizer_unit.sv */
// Top level of the frame intensity normalizer: pixel store, peak tracking, read
// sequencer, three channel lanes and the result register. Uses fin_pkg, fin_ram, fin_lane.
//
// A load does not raise busy, so loads can be issued back to back.
// A read of a loaded pixel keeps busy high through the FETCH, QUAD, SEARCH and FINISH
// states: the pixel store is read at the accepting edge, then FETCH squares each
// channel, QUAD squares it again, SEARCH runs the bit-by-bit quotient search in the
// three lanes side by side, and FINISH merges the lanes into the result register. Its
// result beat is shown in the cycle after FINISH. A read past the loaded count keeps
// busy high only in FINISH, and its result beat is shown in the cycle after it. Each
// result is shown for exactly one cycle on o_valid and is not held, so the receiver must
// take it then; the next beat can be accepted at the edge that ends that cycle.
module frame_intensity_normalizer_unit #(
    parameter int MAX_PIXELS = fin_pkg::MAX_PIXELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  fin_pkg::t_in_beat i_item,
    output logic              busy,
    output logic              o_valid,
    output fin_pkg::t_out_beat o_result
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int XW = (CW > fin_pkg::INDEX_W) ? CW : fin_pkg::INDEX_W;

    fin_pkg::t_state            r_state, n_state;
    logic [fin_pkg::STEP_W-1:0] r_k, n_k;
    logic [CW-1:0]              r_count, n_count;
    logic [fin_pkg::PEAK_W-1:0] r_peak, n_peak;
    logic [fin_pkg::PEAK_W-1:0] r_sq;
    logic                       r_pend, n_pend;
    logic                       r_err;
    logic [fin_pkg::INDEX_W-1:0] r_index;
    logic                       r_valid, n_valid;
    fin_pkg::t_out_beat         r_result, n_result;

    logic                       accept, load_acc, read_acc;
    logic [CW-1:0]              base_count;
    logic                       full, in_range;
    logic [XW-1:0]              idx_ext, count_ext;
    logic [fin_pkg::PIXEL_W-1:0] rdata;
    fin_pkg::t_lane_ctl         ctl;
    logic [fin_pkg::CHAN_W-1:0] q_red, q_green, q_blue;

    assign accept   = start && !busy;
    assign load_acc = accept && (i_item.command == fin_pkg::CMD_LOAD);
    assign read_acc = accept && (i_item.command == fin_pkg::CMD_READ);

    assign base_count = i_item.first ? '0 : r_count;
    assign full       = base_count == CW'(MAX_PIXELS);
    assign idx_ext    = XW'(i_item.pixel_index);
    assign count_ext  = XW'(r_count);
    assign in_range   = idx_ext < count_ext;

    fin_ram #(
        .WIDTH(fin_pkg::PIXEL_W),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (load_acc && !full),
        .i_waddr(base_count[AW-1:0]),
        .i_wdata({i_item.red, i_item.green, i_item.blue}),
        .i_re   (read_acc),
        .i_raddr(idx_ext[AW-1:0]),
        .o_rdata(rdata)
    );

    fin_lane u_lane_red (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_chan(rdata[3*fin_pkg::CHAN_W-1:2*fin_pkg::CHAN_W]),
        .i_peak(r_peak),
        .o_q   (q_red)
    );

    fin_lane u_lane_green (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_chan(rdata[2*fin_pkg::CHAN_W-1:fin_pkg::CHAN_W]),
        .i_peak(r_peak),
        .o_q   (q_green)
    );

    fin_lane u_lane_blue (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_chan(rdata[fin_pkg::CHAN_W-1:0]),
        .i_peak(r_peak),
        .o_q   (q_blue)
    );

    always_comb begin
        n_count = r_count;
        n_peak  = r_peak;
        n_pend  = 1'b0;
        if (r_pend && (r_sq > r_peak)) begin
            n_peak = r_sq;
        end
        if (load_acc) begin
            if (i_item.first) begin
                n_peak = '0;
            end
            if (!full) begin
                n_count = base_count + 1'b1;
                n_pend  = 1'b1;
            end else begin
                n_count = base_count;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_valid  = 1'b0;
        n_result = r_result;
        ctl      = '0;
        ctl.k    = r_k;
        unique case (r_state)
            fin_pkg::ST_IDLE: begin
                if (read_acc) begin
                    n_state = in_range ? fin_pkg::ST_FETCH : fin_pkg::ST_FINISH;
                end
            end
            fin_pkg::ST_FETCH: begin
                ctl.square = 1'b1;
                n_state    = fin_pkg::ST_QUAD;
            end
            fin_pkg::ST_QUAD: begin
                ctl.quad = 1'b1;
                n_k      = '1;
                n_state  = fin_pkg::ST_SEARCH;
            end
            fin_pkg::ST_SEARCH: begin
                ctl.step = 1'b1;
                if (r_k == '0) begin
                    n_state = fin_pkg::ST_FINISH;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            fin_pkg::ST_FINISH: begin
                n_valid            = 1'b1;
                n_result.index_out = r_index;
                if (r_err) begin
                    n_result.red_out   = '0;
                    n_result.green_out = '0;
                    n_result.blue_out  = '0;
                    n_result.status    = fin_pkg::STATUS_RANGE;
                end else begin
                    n_result.status = fin_pkg::STATUS_OK;
                    if (r_peak == '0) begin
                        n_result.red_out   = '0;
                        n_result.green_out = '0;
                        n_result.blue_out  = '0;
                    end else begin
                        n_result.red_out   = q_red;
                        n_result.green_out = q_green;
                        n_result.blue_out  = q_blue;
                    end
                end
                n_state = fin_pkg::ST_IDLE;
            end
            default: begin
                n_state = fin_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fin_pkg::ST_IDLE;
            r_k     <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_count <= n_count;
            r_peak  <= n_peak;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (load_acc) begin
            r_sq <= fin_pkg::PEAK_W'(i_item.red) * fin_pkg::PEAK_W'(i_item.red)
                  + fin_pkg::PEAK_W'(i_item.green) * fin_pkg::PEAK_W'(i_item.green)
                  + fin_pkg::PEAK_W'(i_item.blue) * fin_pkg::PEAK_W'(i_item.blue);
        end
        if (read_acc) begin
            r_index <= i_item.pixel_index;
            r_err   <= !in_range;
        end
    end

    assign busy     = r_state != fin_pkg::ST_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* src/fin_checker.sv */
// Port-level checks for the frame intensity normalizer and the bind that attaches
// them to the top level. Uses fin_pkg and frame_intensity_normalizer_unit.
module fin_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input fin_pkg::t_in_beat  i_item,
    input logic               busy,
    input logic               o_valid,
    input fin_pkg::t_out_beat o_result
);

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == fin_pkg::STATUS_RANGE)
        |-> (o_result.red_out == '0) && (o_result.green_out == '0)
            && (o_result.blue_out == '0))
        else $error("Out-of-range result carries nonzero channels.");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Two result beats in consecutive cycles.");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("Result beat without a preceding busy cycle.");

    a_load_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.command == fin_pkg::CMD_LOAD) |=> !busy && !o_valid)
        else $error("Load beat raised busy or produced a result.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("Activity right after reset.");

endmodule

bind frame_intensity_normalizer_unit fin_checker u_fin_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_valid (o_valid),
    .o_result(o_result)
);
